@@ sv/jcs_pkg.sv @@
// ----------------------------------------------------------------------------
// jcs_pkg: shared types and helpers for the joystick calibrate and scale unit
// Holds the sample count, divider widths, state and phase codes, and the
// per-axis setup and finish logic around the serial divider.
// ----------------------------------------------------------------------------
package jcs_pkg;

	// Samples taken in each calibration phase (1..256)
	localparam int SAMPLE_COUNT = 100;
	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);

	localparam int SMP_W = 8;
	localparam int ACC_W = 16;

	// Divider widths: 16-bit dividend, 9-bit divisor (covers 256)
	localparam int DIVD_W = 16;
	localparam int DIVR_W = 9;
	localparam int STEP_W = $clog2(DIVD_W);
	localparam logic [DIVR_W-1:0] DIVR_COUNT = DIVR_W'(SAMPLE_COUNT);

	localparam logic [SMP_W-1:0] POS_MID = 8'd127;
	localparam logic [SMP_W-1:0] POS_MAX = 8'd255;
	localparam logic [SMP_W-1:0] POS_MIN = 8'd0;
	localparam logic [SMP_W-1:0] LOW_INIT = 8'd255;
	localparam logic [SMP_W-1:0] HIGH_INIT = 8'd0;

	typedef enum logic [1:0] {
		PH_REST   = 2'd0,
		PH_XSWEEP = 2'd1,
		PH_YSWEEP = 2'd2,
		PH_RUN    = 2'd3
	} cal_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_WRITE
	} ctrl_state_t;

	// Divider operands and sign/zero flags of one axis
	typedef struct packed {
		logic [DIVD_W-1:0] dividend;
		logic [DIVR_W-1:0] divisor;
		logic              quo_neg;
		logic              div_zero;
		logic              off_neg;
		logic              off_zero;
	} axis_prep_t;

	// Center the sample, pick the half range and split into magnitudes and signs
	function automatic axis_prep_t prep_axis(
		input logic [SMP_W-1:0] smp,
		input logic [SMP_W-1:0] center,
		input logic [SMP_W-1:0] low,
		input logic [SMP_W-1:0] high
	);
		axis_prep_t       p;
		logic [SMP_W:0]   off;
		logic [SMP_W:0]   off_mag;
		logic [SMP_W:0]   d;
		logic [SMP_W:0]   d_mag;
		logic [DIVD_W-1:0] shifted;
		off = {1'b0, smp} - {1'b0, center};
		off_mag = off[SMP_W] ? (~off + 1'b1) : off;
		shifted = {1'b0, off_mag[SMP_W-1:0], 7'b0};
		if (!off[SMP_W]) begin
			d = {1'b0, high} - {1'b0, center};
			p.dividend = shifted;
		end else begin
			d = {1'b0, center} - {1'b0, low};
			p.dividend = shifted - {8'b0, off_mag[SMP_W-1:0]};
		end
		d_mag = d[SMP_W] ? (~d + 1'b1) : d;
		p.divisor = d_mag;
		p.quo_neg = off[SMP_W] ^ d[SMP_W];
		p.div_zero = (d == '0);
		p.off_neg = off[SMP_W];
		p.off_zero = (off == '0);
		return p;
	endfunction

	// Apply sign, add the midpoint and clamp to the 8-bit range
	function automatic logic [SMP_W-1:0] finish_axis(
		input axis_prep_t        p,
		input logic [DIVD_W-1:0] q
	);
		logic [SMP_W-1:0] r;
		if (p.div_zero) begin
			r = p.off_neg ? POS_MIN : (p.off_zero ? POS_MID : POS_MAX);
		end else if (p.quo_neg) begin
			r = (|q[DIVD_W-1:7]) ? POS_MIN : (POS_MID - q[7:0]);
		end else begin
			r = ((|q[DIVD_W-1:8]) || (q[7] && (|q[6:0]))) ? POS_MAX : (POS_MID + q[7:0]);
		end
		return r;
	endfunction

endpackage

@@ sv/jcs_div.sv @@
// ----------------------------------------------------------------------------
// jcs_div: bit-serial restoring divider
// Unsigned divide of a 16-bit dividend by a 9-bit divisor, one quotient bit
// per cycle; done pulses in the cycle after the last step, quotient then holds.
// ----------------------------------------------------------------------------
module jcs_div
	import jcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVR_W-1:0] divisor,
	output logic [DIVD_W-1:0] quotient,
	output logic              done
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dsr_q;
	logic [DIVD_W-1:0] quo_q;

	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              fits;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		fits = (trial >= {1'b0, dsr_q});
		diff = trial - {1'b0, dsr_q};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= STEP_W'(DIVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done = done_q;

endmodule

@@ sv/joystick_calibrate_and_scale_unit.sv @@
// ----------------------------------------------------------------------------
// joystick_calibrate_and_scale_unit: joystick center/range calibration
// Averages rest samples for the centers, sweeps x then y for the ranges, then
// maps each sample piecewise linearly around 127 with two serial dividers.
// ----------------------------------------------------------------------------
//  channel    direction  handshake                      payload
//  sample     in         sample_valid / sample_stall    x_sample, y_sample, restart
//  position   out        position_valid / position_stall x_position, y_position,
//                                                       calibrating, phase
//
//  Calibration items pass only the idle and write states, except the last rest
//  item, which runs the center divide; it and running items also pass load and
//  divide on the 16-step bit-serial dividers (one per axis, working in parallel).
//  A finished result waits in the output register while the next item is taken.
//  Reset clears all calibration state at once; no clearing pass is needed.
//  sample_stall is high while an item is in work or its result has no slot.
// ----------------------------------------------------------------------------
module joystick_calibrate_and_scale_unit
	import jcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  logic [SMP_W-1:0] x_sample,
	input  logic [SMP_W-1:0] y_sample,
	input  logic             restart,
	output logic             position_valid,
	input  logic             position_stall,
	output logic [SMP_W-1:0] x_position,
	output logic [SMP_W-1:0] y_position,
	output logic             calibrating,
	output logic [1:0]       phase
);

	ctrl_state_t      state_q, state_d;
	cal_phase_t       phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] x_acc_q, y_acc_q;
	logic [SMP_W-1:0] x_center_q, y_center_q;
	logic [SMP_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;

	// Item in work
	logic [SMP_W-1:0] x_smp_q, y_smp_q;
	cal_phase_t       item_phase_q;
	logic             center_job_q;
	axis_prep_t       x_prep_q, y_prep_q;

	// Output register
	logic             out_valid_q;
	logic [SMP_W-1:0] x_pos_q, y_pos_q;
	logic             out_cal_q;
	cal_phase_t       out_phase_q;

	// Effective calibration state after an optional restart
	cal_phase_t       eff_phase;
	logic [CNT_W-1:0] eff_cnt;
	logic [ACC_W-1:0] eff_x_acc, eff_y_acc;
	logic [SMP_W-1:0] eff_x_low, eff_x_high, eff_y_low, eff_y_high;
	logic             last_smp;

	logic             take_in;
	logic             slot_free;
	logic             load_out;
	logic             div_start;
	logic [DIVD_W-1:0] x_dividend, y_dividend;
	logic [DIVR_W-1:0] x_divisor, y_divisor;
	logic [DIVD_W-1:0] x_quo, y_quo;
	logic             x_done, y_done;
	axis_prep_t       x_prep, y_prep;

	assign slot_free = !out_valid_q || !position_stall;
	assign take_in = sample_valid && !sample_stall;

	// Restart clears everything before the item is counted
	always_comb begin
		if (restart) begin
			eff_phase = PH_REST;
			eff_cnt = '0;
			eff_x_acc = '0;
			eff_y_acc = '0;
			eff_x_low = LOW_INIT;
			eff_x_high = HIGH_INIT;
			eff_y_low = LOW_INIT;
			eff_y_high = HIGH_INIT;
		end else begin
			eff_phase = phase_q;
			eff_cnt = cnt_q;
			eff_x_acc = x_acc_q;
			eff_y_acc = y_acc_q;
			eff_x_low = x_low_q;
			eff_x_high = x_high_q;
			eff_y_low = y_low_q;
			eff_y_high = y_high_q;
		end
		last_smp = (eff_cnt >= CNT_LAST);
	end

	// Next state and handshake
	always_comb begin
		state_d = state_q;
		sample_stall = 1'b1;
		div_start = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					if ((eff_phase == PH_RUN) || (eff_phase == PH_REST && last_smp)) begin
						state_d = ST_LOAD;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_LOAD: begin
				div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (x_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Set up divider operands for a center divide or a scaling divide
	always_comb begin
		x_prep = prep_axis(x_smp_q, x_center_q, x_low_q, x_high_q);
		y_prep = prep_axis(y_smp_q, y_center_q, y_low_q, y_high_q);
		if (center_job_q) begin
			x_dividend = x_acc_q;
			y_dividend = y_acc_q;
			x_divisor = DIVR_COUNT;
			y_divisor = DIVR_COUNT;
		end else begin
			x_dividend = x_prep.dividend;
			y_dividend = y_prep.dividend;
			x_divisor = x_prep.divisor;
			y_divisor = y_prep.divisor;
		end
	end

	jcs_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (x_dividend),
		.divisor  (x_divisor),
		.quotient (x_quo),
		.done     (x_done)
	);

	jcs_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (y_dividend),
		.divisor  (y_divisor),
		.quotient (y_quo),
		.done     (y_done)
	);

	// Calibration state: count, accumulate, sweep, latch centers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_REST;
			cnt_q <= '0;
			x_acc_q <= '0;
			y_acc_q <= '0;
			x_center_q <= '0;
			y_center_q <= '0;
			x_low_q <= LOW_INIT;
			x_high_q <= HIGH_INIT;
			y_low_q <= LOW_INIT;
			y_high_q <= HIGH_INIT;
			center_job_q <= 1'b0;
		end else begin
			if (take_in) begin
				phase_q <= eff_phase;
				cnt_q <= eff_cnt;
				x_acc_q <= eff_x_acc;
				y_acc_q <= eff_y_acc;
				x_low_q <= eff_x_low;
				x_high_q <= eff_x_high;
				y_low_q <= eff_y_low;
				y_high_q <= eff_y_high;
				center_job_q <= 1'b0;
				if (restart) begin
					x_center_q <= '0;
					y_center_q <= '0;
				end
				if (eff_phase != PH_RUN) begin
					cnt_q <= last_smp ? '0 : (eff_cnt + 1'b1);
				end
				case (eff_phase)
					PH_REST: begin
						x_acc_q <= eff_x_acc + ACC_W'(x_sample);
						y_acc_q <= eff_y_acc + ACC_W'(y_sample);
						if (last_smp) begin
							center_job_q <= 1'b1;
							phase_q <= PH_XSWEEP;
						end
					end
					PH_XSWEEP: begin
						if (x_sample > eff_x_high) begin
							x_high_q <= x_sample;
						end
						if (x_sample < eff_x_low) begin
							x_low_q <= x_sample;
						end
						if (last_smp) begin
							phase_q <= PH_YSWEEP;
						end
					end
					PH_YSWEEP: begin
						if (y_sample > eff_y_high) begin
							y_high_q <= y_sample;
						end
						if (y_sample < eff_y_low) begin
							y_low_q <= y_sample;
						end
						if (last_smp) begin
							phase_q <= PH_RUN;
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_DIV && x_done && center_job_q) begin
				x_center_q <= x_quo[SMP_W-1:0];
				y_center_q <= y_quo[SMP_W-1:0];
			end
		end
	end

	// Hold the item's samples and tag; keep the axis flags for the finish step
	always_ff @(posedge clk) begin
		if (take_in) begin
			x_smp_q <= x_sample;
			y_smp_q <= y_sample;
			item_phase_q <= eff_phase;
		end
		if (div_start) begin
			x_prep_q <= x_prep;
			y_prep_q <= y_prep;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!position_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_phase_q <= item_phase_q;
			if (item_phase_q == PH_RUN) begin
				x_pos_q <= finish_axis(x_prep_q, x_quo);
				y_pos_q <= finish_axis(y_prep_q, y_quo);
				out_cal_q <= 1'b0;
			end else begin
				x_pos_q <= POS_MID;
				y_pos_q <= POS_MID;
				out_cal_q <= 1'b1;
			end
		end
	end

	assign position_valid = out_valid_q;
	assign x_position = x_pos_q;
	assign y_position = y_pos_q;
	assign calibrating = out_cal_q;
	assign phase = out_phase_q;

	// Both dividers start together and must finish together
	assert property (@(posedge clk) disable iff (!arst_n)
		x_done == y_done)
		else $error("axis dividers out of step");

	// An accepted item always leaves the idle state
	assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> state_q != ST_IDLE)
		else $error("accepted item not started");

	// A result loaded into the output register is presented next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result lost at output register");

	// Only running items leave calibration
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_cal_q) |-> (out_phase_q == PH_RUN))
		else $error("scaled result outside running phase");

endmodule
